### sv/pkcs1_signature_block_checker_defines.svh
// Assertion macros shared by the signature block checker RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef PKCS1_SIGNATURE_BLOCK_CHECKER_DEFINES_SVH
`define PKCS1_SIGNATURE_BLOCK_CHECKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/psbc_pkg.sv
// Package for the signature block checker: constants, register map, verdict codes.
// Used by pkcs1_signature_block_checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package psbc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_MAX_BLOCK_BYTES = 512;
  localparam int DEF_MAX_HASH_BYTES  = 32;

  // Fixed field widths.
  localparam int BYTE_W     = 8;
  localparam int VERDICT_W  = 2;
  localparam int PAD_W      = 9;
  localparam int HLEN_W     = 6;
  localparam int HPOS_W     = 6;
  localparam int NPOS_W     = 3;
  localparam int HWORDS     = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int OUT_DATA_W = 16;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_BAD      = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_MISMATCH = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_MATCH    = 2'd2;

  // Register indexes (byte address is eight times the index).
  localparam logic [2:0] REG_HASH_W0  = 3'd0;
  localparam logic [2:0] REG_HASH_W1  = 3'd1;
  localparam logic [2:0] REG_HASH_W2  = 3'd2;
  localparam logic [2:0] REG_HASH_W3  = 3'd3;
  localparam logic [2:0] REG_HASH_LEN = 3'd4;

  localparam logic [HLEN_W-1:0] HASH_LEN_RESET = 6'd20;

  // Layout bytes.
  localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE   = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_FF    = 8'hff;
  localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;
  localparam logic [BYTE_W-1:0] CHAR_TWO   = 8'h32;

  // Characters of the long hash name "sha256", by position.
  function automatic logic [BYTE_W-1:0] name_char(input logic [NPOS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h73;
      3'd1:    c = 8'h68;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h32;
      3'd4:    c = 8'h35;
      3'd5:    c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/pkcs1_signature_block_checker.sv
// Signature block padding checker: byte stream in, one verdict word per block out.
// Depends on psbc_pkg and pkcs1_signature_block_checker_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes a decrypted signature block one byte per word on the slave stream and
// checks the layout 00 01 FF.. 00, the name "sha1" or "sha256" and the expected
// hash bytes; trailing bytes are ignored. One result word leaves on the master
// stream for the byte marked tlast. The per-byte state update is a single pass
// of logic into the block state registers, and the verdict goes into an output
// register, so a byte can be accepted on every clock while the result is not
// stalled. A block longer than MAX_BLOCK_BYTES or one that ends before its hash
// is complete is reported as bad format. The expected hash and its length must
// be written over the APB port only while idle; the block does not check this.
module pkcs1_signature_block_checker #(
  parameter int MAX_BLOCK_BYTES = psbc_pkg::DEF_MAX_BLOCK_BYTES,
  parameter int MAX_HASH_BYTES  = psbc_pkg::DEF_MAX_HASH_BYTES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Byte stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [psbc_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] block_byte
  input  wire logic                                 s_axis_tlast,  // is_last
  // Result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [psbc_pkg::OUT_DATA_W-1:0]           m_axis_tdata,  // [1:0] verdict,
                                                                   // [10:2] pad_bytes,
                                                                   // [15:11] zero
  output logic                                      m_axis_tuser,  // hash_kind
  // Configuration
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [psbc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [psbc_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [psbc_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                      pready
);
  import psbc_pkg::*;

  localparam int BCNT_W = $clog2(MAX_BLOCK_BYTES + 2);

  typedef enum logic [2:0] {
    PH_ZERO, PH_ONE, PH_PAD, PH_NAME, PH_HASH, PH_TAIL, PH_BAD
  } phase_t;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] hash_word [HWORDS];
  logic [HLEN_W-1:0]     hash_length;

  // Block state.
  phase_t             phase, phase_next;
  logic [NPOS_W-1:0]  name_position, name_position_next;
  logic               name_is_long, name_is_long_next;
  logic [HPOS_W-1:0]  hash_position, hash_position_next;
  logic               mismatch_seen, mismatch_seen_next;
  logic [PAD_W-1:0]   pad_counter, pad_counter_next;
  logic [BCNT_W-1:0]  byte_counter, byte_counter_next;

  // Result register.
  logic [VERDICT_W-1:0] verdict, verdict_next;
  logic [PAD_W-1:0]     pad_bytes;
  logic                 hash_kind;

  logic                 in_take;
  logic                 cfg_write;
  logic [HLEN_W-1:0]    hash_limit;
  logic [BYTE_W-1:0]    expected_byte;
  logic [HPOS_W-1:0]    hash_position_inc;
  logic [2:0]           cfg_index;

  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign cfg_write     = psel && penable && pwrite && pready;
  assign cfg_index     = paddr[CFG_ADDR_W-1:3];
  assign pready        = 1'b1;

  // Hash length clipped to the largest supported hash.
  assign hash_limit = (hash_length > HLEN_W'(MAX_HASH_BYTES)) ?
                      HLEN_W'(MAX_HASH_BYTES) : hash_length;

  // Expected byte at the current hash position.
  assign expected_byte     = hash_word[hash_position[4:3]][{hash_position[2:0], 3'b000} +: BYTE_W];
  assign hash_position_inc = hash_position + HPOS_W'(1);

  // Register write and read decode.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HWORDS; i++) hash_word[i] <= '0;
      hash_length <= HASH_LEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HASH_W0:  hash_word[0] <= pwdata;
        REG_HASH_W1:  hash_word[1] <= pwdata;
        REG_HASH_W2:  hash_word[2] <= pwdata;
        REG_HASH_W3:  hash_word[3] <= pwdata;
        REG_HASH_LEN: hash_length  <= pwdata[HLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_HASH_W0:  prdata = hash_word[0];
      REG_HASH_W1:  prdata = hash_word[1];
      REG_HASH_W2:  prdata = hash_word[2];
      REG_HASH_W3:  prdata = hash_word[3];
      REG_HASH_LEN: prdata = CFG_DATA_W'(hash_length);
      default:      prdata = '0;
    endcase
  end

  // Per-byte step of the layout check.
  always_comb begin
    phase_next         = phase;
    name_position_next = name_position;
    name_is_long_next  = name_is_long;
    hash_position_next = hash_position;
    mismatch_seen_next = mismatch_seen;
    pad_counter_next   = pad_counter;
    byte_counter_next  = byte_counter;

    if (byte_counter <= BCNT_W'(MAX_BLOCK_BYTES)) begin
      byte_counter_next = byte_counter + BCNT_W'(1);
    end

    unique case (phase)
      PH_ZERO: phase_next = (s_axis_tdata == BYTE_ZERO) ? PH_ONE : PH_BAD;
      PH_ONE:  phase_next = (s_axis_tdata == BYTE_ONE) ? PH_PAD : PH_BAD;
      PH_PAD: begin
        if (s_axis_tdata == BYTE_ZERO) begin
          phase_next         = PH_NAME;
          name_position_next = '0;
        end else if (s_axis_tdata == BYTE_FF) begin
          if (pad_counter != '1) pad_counter_next = pad_counter + PAD_W'(1);
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_NAME: begin
        if (name_position < 3'd3) begin
          if (s_axis_tdata == name_char(name_position)) begin
            name_position_next = name_position + 3'd1;
          end else begin
            phase_next = PH_BAD;
          end
        end else if (name_position == 3'd3) begin
          if (s_axis_tdata == CHAR_ONE) begin
            // Short name complete: move on to the hash.
            name_is_long_next  = 1'b0;
            hash_position_next = '0;
            phase_next         = (hash_limit == '0) ? PH_TAIL : PH_HASH;
          end else if (s_axis_tdata == CHAR_TWO) begin
            name_is_long_next  = 1'b1;
            name_position_next = 3'd4;
          end else begin
            phase_next = PH_BAD;
          end
        end else if (name_position < 3'd6 && s_axis_tdata == name_char(name_position)) begin
          name_position_next = name_position + 3'd1;
          if (name_position == 3'd5) begin
            hash_position_next = '0;
            phase_next         = (hash_limit == '0) ? PH_TAIL : PH_HASH;
          end
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_HASH: begin
        if (hash_position >= hash_limit) begin
          phase_next = PH_TAIL;
        end else begin
          if (s_axis_tdata != expected_byte) mismatch_seen_next = 1'b1;
          hash_position_next = hash_position_inc;
          if (hash_position_inc >= hash_limit) phase_next = PH_TAIL;
        end
      end
      default: ;
    endcase

    // Verdict as it stands after this byte.
    if (byte_counter_next > BCNT_W'(MAX_BLOCK_BYTES) || phase_next != PH_TAIL) begin
      verdict_next = VERDICT_BAD;
    end else begin
      verdict_next = mismatch_seen_next ? VERDICT_MISMATCH : VERDICT_MATCH;
    end
  end

  // Block state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_ZERO;
      name_position <= '0;
      name_is_long  <= 1'b0;
      hash_position <= '0;
      mismatch_seen <= 1'b0;
      pad_counter   <= '0;
      byte_counter  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // A new result word takes the place of one that leaves in the same cycle.
      if (in_take && s_axis_tlast) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_take) begin
        if (s_axis_tlast) begin
          // End of block: emit the result and start afresh.
          phase         <= PH_ZERO;
          name_position <= '0;
          name_is_long  <= 1'b0;
          hash_position <= '0;
          mismatch_seen <= 1'b0;
          pad_counter   <= '0;
          byte_counter  <= '0;
        end else begin
          phase         <= phase_next;
          name_position <= name_position_next;
          name_is_long  <= name_is_long_next;
          hash_position <= hash_position_next;
          mismatch_seen <= mismatch_seen_next;
          pad_counter   <= pad_counter_next;
          byte_counter  <= byte_counter_next;
        end
      end
    end
  end

  // Result payload, loaded only with a new result word.
  always_ff @(posedge clk) begin
    if (in_take && s_axis_tlast) begin
      verdict   <= verdict_next;
      pad_bytes <= (verdict_next == VERDICT_BAD) ? '0 : pad_counter_next;
      hash_kind <= (verdict_next == VERDICT_BAD) ? 1'b0 : name_is_long_next;
    end
  end

  assign m_axis_tdata = {5'b0, pad_bytes, verdict};
  assign m_axis_tuser = hash_kind;

  // Checks on the block's own logic.
`include "pkcs1_signature_block_checker_defines.svh"

  `PSBC_ASSERT_NOW(a_no_take_when_stalled, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "byte accepted while result stalled")
  `PSBC_ASSERT_NEXT(a_clear_after_last, clk, rst, in_take && s_axis_tlast, phase == PH_ZERO && byte_counter == '0 && pad_counter == '0, "block state not cleared after last byte")
  `PSBC_ASSERT_NOW(a_bad_fields_zero, clk, rst, m_axis_tvalid && verdict == VERDICT_BAD, pad_bytes == '0 && !hash_kind, "bad format result carries pad count or kind")
  `PSBC_ASSERT_NOW(a_verdict_code, clk, rst, m_axis_tvalid, verdict == VERDICT_BAD || verdict == VERDICT_MISMATCH || verdict == VERDICT_MATCH, "undefined verdict code")

endmodule

`default_nettype wire
